// ----- hw/rtl/two_wire_segment_display_writer_unit_assert.svh -----
// Assertion macros for the two-wire segment display writer.
// Included by the top level; it relies on clk and rst_n in the including scope.
`ifndef TWO_WIRE_SEGMENT_DISPLAY_WRITER_UNIT_ASSERT_SVH
`define TWO_WIRE_SEGMENT_DISPLAY_WRITER_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TSDW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TSDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tsdw_pkg.sv -----
// Shared types and constants for the two-wire segment display writer.
// Depends on nothing; every module of the block imports it.
package tsdw_pkg;

    localparam int MAX_DIGITS_DEF = 4;
    localparam int DIGIT_FIELDS   = 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;

    localparam logic [1:0] REQ_DATA = 2'd0;
    localparam logic [1:0] REQ_ADDR = 2'd1;
    localparam logic [1:0] REQ_CTRL = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_CMD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_CMD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_CMD = 3'd4;

    localparam logic [7:0] DATA_CMD_RST    = 8'h40;
    localparam logic [7:0] ADDRESS_CMD_RST = 8'hC0;
    localparam logic [7:0] CONTROL_CMD_RST = 8'h80;
    localparam logic [2:0] BIT_LAST        = 3'd7;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] digit_zero;
        logic [7:0] digit_one;
        logic [7:0] digit_two;
        logic [7:0] digit_three;
        logic [2:0] digit_count;
        logic [1:0] first_position;
        logic [4:0] ack_levels;
    } req_word_t;

    typedef struct packed {
        logic [1:0] slot_kind;
        logic       dio_level;
        logic       dio_released;
        logic       ack_seen;
        logic       last;
    } slot_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hw/rtl/tsdw_front.sv -----
// Front end: holds the configuration registers, takes request words and turns
// each, REQ_NONE aside, into a job (bytes, ack levels, count). Uses tsdw_pkg.
module tsdw_front #(
    parameter int MAX_DIGITS = tsdw_pkg::MAX_DIGITS_DEF,
    parameter int JOB_W      = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tsdw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsdw_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  tsdw_pkg::req_word_t                  req,
    input  tsdw_pkg::q_status_t                  qstat,
    output logic                                 push,
    output logic [JOB_W-1:0]                     job
);
    import tsdw_pkg::*;

    localparam int NUM_DIG = (MAX_DIGITS < DIGIT_FIELDS) ? MAX_DIGITS : DIGIT_FIELDS;
    localparam int NB      = NUM_DIG + 1;
    localparam int CNT_W   = $clog2(NB + 1);

    typedef struct packed {
        logic [NB-1:0][7:0]  bytes;
        logic [NB-1:0]       acks;
        logic [CNT_W-1:0]    count;
    } job_t;

    logic [2:0] brightness_reg, brightness_next;
    logic       display_on_reg, display_on_next;
    logic [7:0] data_cmd_reg, data_cmd_next;
    logic [7:0] address_cmd_reg, address_cmd_next;
    logic [7:0] control_cmd_reg, control_cmd_next;

    logic [DIGIT_FIELDS-1:0][7:0] digits;
    logic [2:0]                   ndig;
    job_t                         job_w;

    always_comb
    begin
        brightness_next  = brightness_reg;
        display_on_next  = display_on_reg;
        data_cmd_next    = data_cmd_reg;
        address_cmd_next = address_cmd_reg;
        control_cmd_next = control_cmd_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_BRIGHTNESS:  brightness_next  = cfg_data[2:0];
                REG_DISPLAY_ON:  display_on_next  = cfg_data[0];
                REG_DATA_CMD:    data_cmd_next    = cfg_data;
                REG_ADDRESS_CMD: address_cmd_next = cfg_data;
                REG_CONTROL_CMD: control_cmd_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= '0;
            display_on_reg  <= 1'b0;
            data_cmd_reg    <= DATA_CMD_RST;
            address_cmd_reg <= ADDRESS_CMD_RST;
            control_cmd_reg <= CONTROL_CMD_RST;
        end
        else
        begin
            brightness_reg  <= brightness_next;
            display_on_reg  <= display_on_next;
            data_cmd_reg    <= data_cmd_next;
            address_cmd_reg <= address_cmd_next;
            control_cmd_reg <= control_cmd_next;
        end
    end

    assign digits = {req.digit_three, req.digit_two, req.digit_one, req.digit_zero};
    assign ndig   = (req.digit_count > 3'(NUM_DIG)) ? 3'(NUM_DIG) : req.digit_count;

    always_comb
    begin
        job_w       = '0;
        job_w.acks  = req.ack_levels[NB-1:0];
        job_w.count = CNT_W'(1);
        for (int k = 0; k < NUM_DIG; k++)
        begin
            job_w.bytes[k + 1] = digits[k];
        end
        case (req.req_type)
            REQ_DATA: job_w.bytes[0] = data_cmd_reg;
            REQ_ADDR:
            begin
                job_w.bytes[0] = address_cmd_reg + {6'd0, req.first_position};
                job_w.count    = CNT_W'(ndig) + CNT_W'(1);
            end
            REQ_CTRL: job_w.bytes[0] = control_cmd_reg + {4'd0, display_on_reg, brightness_reg};
            default:  job_w.bytes[0] = data_cmd_reg;
        endcase
    end

    // A request of the unused type is taken and dropped without a job.
    assign req_ready = !qstat.full;
    assign push      = req_valid && req_ready && (req.req_type != REQ_NONE);
    assign job       = job_w;

endmodule

// ----- hw/rtl/tsdw_queue.sv -----
// Short job queue between the front and back ends of the display writer.
// Depth comes from tsdw_pkg; the job width is a parameter.
module tsdw_queue #(
    parameter int WIDTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     head,
    output tsdw_pkg::q_status_t  qstat
);
    import tsdw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + LVL_W'(push) - LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head        = mem[rd_ptr_reg];
    assign qstat.full  = (level_reg == LVL_W'(QUEUE_DEPTH));
    assign qstat.empty = (level_reg == '0);

endmodule

// ----- hw/rtl/tsdw_back.sv -----
// Back end: takes a job from the queue and sends its bit slots one at a time
// through an output register. Uses tsdw_pkg.
module tsdw_back #(
    parameter int MAX_DIGITS = tsdw_pkg::MAX_DIGITS_DEF,
    parameter int JOB_W      = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [JOB_W-1:0]      job,
    input  tsdw_pkg::q_status_t   qstat,
    output logic                  pop,
    output logic                  slot_valid,
    input  logic                  slot_ready,
    output tsdw_pkg::slot_word_t  slot
);
    import tsdw_pkg::*;

    localparam int NUM_DIG = (MAX_DIGITS < DIGIT_FIELDS) ? MAX_DIGITS : DIGIT_FIELDS;
    localparam int NB      = NUM_DIG + 1;
    localparam int CNT_W   = $clog2(NB + 1);

    typedef struct packed {
        logic [NB-1:0][7:0]  bytes;
        logic [NB-1:0]       acks;
        logic [CNT_W-1:0]    count;
    } job_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_BIT   = 5'b00100,
        S_ACK   = 5'b01000,
        S_STOP  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [8*NB-1:0]   shift_reg, shift_next;
    logic [NB-1:0]     acks_reg, acks_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [2:0]        bit_cnt_reg, bit_cnt_next;
    logic              valid_reg, valid_next;
    slot_word_t        slot_reg, slot_next;
    job_t              job_w;
    logic              emit;

    assign job_w = job;
    assign emit  = (state_reg != S_IDLE) && (!valid_reg || slot_ready);

    always_comb
    begin
        state_next   = state_reg;
        shift_next   = shift_reg;
        acks_next    = acks_reg;
        left_next    = left_reg;
        bit_cnt_next = bit_cnt_reg;
        slot_next    = slot_reg;
        pop          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    shift_next = job_w.bytes;
                    acks_next  = job_w.acks;
                    left_next  = job_w.count;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (emit)
                begin
                    slot_next    = '{KIND_START, 1'b0, 1'b0, 1'b0, 1'b0};
                    bit_cnt_next = '0;
                    state_next   = S_BIT;
                end
            end
            S_BIT:
            begin
                if (emit)
                begin
                    slot_next    = '{KIND_DATA, shift_reg[0], 1'b0, 1'b0, 1'b0};
                    shift_next   = shift_reg >> 1;
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == BIT_LAST)
                    begin
                        state_next = S_ACK;
                    end
                end
            end
            S_ACK:
            begin
                if (emit)
                begin
                    slot_next = '{KIND_ACK, acks_reg[0], 1'b1, acks_reg[0], 1'b0};
                    acks_next = acks_reg >> 1;
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = S_STOP;
                    end
                    else
                    begin
                        left_next    = left_reg - CNT_W'(1);
                        bit_cnt_next = '0;
                        state_next   = S_BIT;
                    end
                end
            end
            S_STOP:
            begin
                if (emit)
                begin
                    slot_next  = '{KIND_STOP, 1'b1, 1'b0, 1'b0, 1'b1};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (slot_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= 1'b0;
            left_reg    <= '0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            left_reg    <= left_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        acks_reg  <= acks_next;
        slot_reg  <= slot_next;
    end

    assign slot_valid = valid_reg;
    assign slot       = slot_reg;

endmodule

// ----- hw/rtl/two_wire_segment_display_writer_unit.sv -----
// Channel   Direction  Handshake                Word
// req       in         req_valid / req_ready    tsdw_pkg::req_word_t
// slot      out        slot_valid / slot_ready  tsdw_pkg::slot_word_t
// cfg       in         cfg_write                cfg_index, cfg_data
//
// A transaction sends 1 + 9 * bytes + 1 slots, 11 to 47, one slot per clock
// while slot_ready is high, plus the idle state in which the job is popped.
// The back end's slot sequencer sets this rate; the front end takes a request
// whenever the two-entry job queue has room.
// Reset is asynchronous and needs no clearing pass.
// A stalled output holds its slot word; requests come in until the queue is full.
module two_wire_segment_display_writer_unit #(
    parameter int MAX_DIGITS = tsdw_pkg::MAX_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tsdw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsdw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  tsdw_pkg::req_word_t              req,
    output logic                             slot_valid,
    input  logic                             slot_ready,
    output tsdw_pkg::slot_word_t             slot
);
    import tsdw_pkg::*;

    localparam int NUM_DIG = (MAX_DIGITS < DIGIT_FIELDS) ? MAX_DIGITS : DIGIT_FIELDS;
    localparam int NB      = NUM_DIG + 1;
    localparam int JOB_W   = 8 * NB + NB + $clog2(NB + 1);

    logic              push;
    logic              pop;
    logic [JOB_W-1:0]  job_in;
    logic [JOB_W-1:0]  job_head;
    q_status_t         qstat;

    tsdw_front #(
        .MAX_DIGITS (MAX_DIGITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .qstat     (qstat),
        .push      (push),
        .job       (job_in)
    );

    tsdw_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job_in),
        .pop       (pop),
        .head      (job_head),
        .qstat     (qstat)
    );

    tsdw_back #(
        .MAX_DIGITS (MAX_DIGITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job_head),
        .qstat      (qstat),
        .pop        (pop),
        .slot_valid (slot_valid),
        .slot_ready (slot_ready),
        .slot       (slot)
    );

`include "two_wire_segment_display_writer_unit_assert.svh"

    `TSDW_ASSERT_NOW(a_no_push_full, push, !qstat.full, "Job pushed into a full queue.")
    `TSDW_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty, "Job taken from an empty queue.")
    `TSDW_ASSERT_NOW(a_last_is_stop, slot_valid && slot.last, slot.slot_kind == KIND_STOP, "Last word is not a stop slot.")
    `TSDW_ASSERT_NOW(a_release_ack, slot_valid, slot.dio_released == (slot.slot_kind == KIND_ACK), "Line released outside an ack slot.")
    `TSDW_ASSERT_NEXT(a_stop_then_start, slot_valid && slot_ready && slot.last && slot_valid, !slot_valid || slot.slot_kind == KIND_START, "Word after a stop is not a start.")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for two_wire_segment_display_writer_unit.
// Depends on tsdw_pkg; it predicts every bit slot of each framed transaction
// and compares the slot words in order, under random idling on both channels.
module testbench;
    import tsdw_pkg::*;

    localparam int DIGIT_LIMIT = (MAX_DIGITS_DEF < DIGIT_FIELDS) ? MAX_DIGITS_DEF : DIGIT_FIELDS;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_WORDS = 42;
    localparam int RANDOM_PHASES = 5;
    localparam int STEADY_PHASE = 2;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] value;
        req_word_t word;
        bit cmd_typed;
        logic [7:0] cmd;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic req_valid;
    logic req_ready;
    req_word_t req;
    logic slot_valid;
    logic slot_ready = 1'b0;
    slot_word_t slot;

    logic [2:0] cur_brightness;
    logic cur_display_on;
    logic [7:0] cur_data_cmd;
    logic [7:0] cur_address_cmd;
    logic [7:0] cur_control_cmd;

    slot_word_t slot_queue[$];
    int mismatches = 0;
    bit steady = 1'b0;
    bit pending = 1'b0;

    two_wire_segment_display_writer_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .slot_valid(slot_valid),
        .slot_ready(slot_ready),
        .slot(slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [7:0] command_byte(input req_word_t w);
        case (w.req_type)
            REQ_DATA: return cur_data_cmd;
            REQ_ADDR: return cur_address_cmd + 8'(w.first_position);
            default: return cur_control_cmd + {4'd0, cur_display_on, cur_brightness};
        endcase
    endfunction

    function automatic void queue_slot(input logic [1:0] kind, input logic level,
                                       input logic released, input logic ack,
                                       input logic fin);
        slot_word_t s;
        s.slot_kind = kind;
        s.dio_level = level;
        s.dio_released = released;
        s.ack_seen = ack;
        s.last = fin;
        slot_queue.push_back(s);
    endfunction

    function automatic void queue_byte(input logic [7:0] value, input logic ack_level);
        for (int i = 0; i < 8; i++)
            queue_slot(KIND_DATA, value[i], 1'b0, 1'b0, 1'b0);
        queue_slot(KIND_ACK, ack_level, 1'b1, ack_level, 1'b0);
    endfunction

    function automatic void queue_transaction(input req_word_t w, input logic [7:0] cmd);
        int count;
        logic [7:0] digits [4];
        if (w.req_type == REQ_NONE)
            return;
        digits = '{w.digit_zero, w.digit_one, w.digit_two, w.digit_three};
        queue_slot(KIND_START, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_byte(cmd, w.ack_levels[0]);
        if (w.req_type == REQ_ADDR)
        begin
            count = (w.digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(w.digit_count);
            for (int k = 0; k < count; k++)
                queue_byte(digits[k], w.ack_levels[k + 1]);
        end
        queue_slot(KIND_STOP, 1'b1, 1'b0, 1'b0, 1'b1);
    endfunction

    function automatic plan_row_t req_row(input logic [1:0] kind, input logic [7:0] d0,
                                          input logic [7:0] d1, input logic [7:0] d2,
                                          input logic [7:0] d3, input logic [2:0] count,
                                          input logic [1:0] pos, input logic [4:0] acks,
                                          input bit typed, input logic [7:0] cmd);
        plan_row_t r;
        r.kind = ROW_REQ;
        r.index = '0;
        r.value = '0;
        r.word = '{kind, d0, d1, d2, d3, count, pos, acks};
        r.cmd_typed = typed;
        r.cmd = cmd;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] index,
                                          input logic [7:0] value);
        plan_row_t r;
        r.kind = ROW_CFG;
        r.index = index;
        r.value = value;
        r.word = '0;
        r.cmd_typed = 1'b0;
        r.cmd = '0;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic req_word_t random_request();
        req_word_t w;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            w.req_type = REQ_NONE;
        else if (pick < 25)
            w.req_type = REQ_DATA;
        else if (pick < 75)
            w.req_type = REQ_ADDR;
        else
            w.req_type = REQ_CTRL;
        w.digit_zero = 8'($urandom);
        w.digit_one = 8'($urandom);
        w.digit_two = 8'($urandom);
        w.digit_three = 8'($urandom);
        if ($urandom_range(99) < 80)
            w.digit_count = 3'($urandom_range(DIGIT_FIELDS));
        else
            w.digit_count = 3'($urandom_range(7, DIGIT_FIELDS + 1));
        w.first_position = 2'($urandom);
        w.ack_levels = 5'($urandom);
        return w;
    endfunction

    task automatic settle();
        req_valid <= 1'b0;
        while (slot_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        pending = 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
        if (pending)
            settle();
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (index)
            REG_BRIGHTNESS: cur_brightness = value[2:0];
            REG_DISPLAY_ON: cur_display_on = value[0];
            REG_DATA_CMD: cur_data_cmd = value;
            REG_ADDRESS_CMD: cur_address_cmd = value;
            REG_CONTROL_CMD: cur_control_cmd = value;
            default: ;
        endcase
    endtask

    task automatic push_request(input req_word_t w, input bit typed, input logic [7:0] cmd);
        while (!steady && $urandom_range(99) < 21)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        queue_transaction(w, typed ? cmd : command_byte(w));
        pending = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_ready <= 1'b0;
        else
            slot_ready <= steady || ($urandom_range(99) >= 21);
    end

    always @(posedge clk)
    begin : slot_check
        slot_word_t want;
        if (rst_n && slot_valid && slot_ready)
        begin
            if (slot_queue.size() == 0)
                report_mismatch("slot word with nothing expected, kind", slot.slot_kind, -1);
            else
            begin
                want = slot_queue.pop_front();
                if (slot.slot_kind !== want.slot_kind)
                    report_mismatch("slot_kind", slot.slot_kind, want.slot_kind);
                if (slot.dio_level !== want.dio_level)
                    report_mismatch("dio_level", slot.dio_level, want.dio_level);
                if (slot.dio_released !== want.dio_released)
                    report_mismatch("dio_released", slot.dio_released, want.dio_released);
                if (slot.ack_seen !== want.ack_seen)
                    report_mismatch("ack_seen", slot.ack_seen, want.ack_seen);
                if (slot.last !== want.last)
                    report_mismatch("last", slot.last, want.last);
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t plan[$];
        req_word_t w;
        int counted;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        cur_brightness = '0;
        cur_display_on = 1'b0;
        cur_data_cmd = DATA_CMD_RST;
        cur_address_cmd = ADDRESS_CMD_RST;
        cur_control_cmd = CONTROL_CMD_RST;

        plan.push_back(req_row(REQ_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 5'h00,
                               1, 8'h40));
        plan.push_back(req_row(REQ_ADDR, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 5'h1F,
                               1, 8'hC0));
        plan.push_back(req_row(REQ_ADDR, 8'h00, 8'hFF, 8'hA5, 8'h5A, 3'd4, 2'd3, 5'h15,
                               1, 8'hC3));
        plan.push_back(req_row(REQ_CTRL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 2'd3, 5'h1E,
                               1, 8'h80));
        plan.push_back(req_row(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 2'd3, 5'h1F,
                               1, 8'h00));
        plan.push_back(req_row(REQ_ADDR, 8'h3C, 8'hC3, 8'h81, 8'h7E, 3'd7, 2'd2, 5'h0A,
                               1, 8'hC2));
        plan.push_back(req_row(REQ_ADDR, 8'h12, 8'h34, 8'h56, 8'h78, 3'd5, 2'd1, 5'h1B,
                               0, 8'h00));
        plan.push_back(cfg_row(REG_BRIGHTNESS, 8'hFF));
        plan.push_back(cfg_row(REG_DISPLAY_ON, 8'hFF));
        plan.push_back(cfg_row(REG_DATA_CMD, 8'hFF));
        plan.push_back(cfg_row(REG_ADDRESS_CMD, 8'hFF));
        plan.push_back(cfg_row(REG_CONTROL_CMD, 8'hFF));
        plan.push_back(req_row(REQ_CTRL, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 5'h1F,
                               1, 8'h0E));
        plan.push_back(req_row(REQ_ADDR, 8'h01, 8'h80, 8'hF0, 8'h0F, 3'd4, 2'd3, 5'h00,
                               1, 8'h02));
        plan.push_back(req_row(REQ_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 5'h01,
                               1, 8'hFF));
        plan.push_back(req_row(REQ_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 5'h00,
                               1, 8'h00));
        plan.push_back(cfg_row(REG_BRIGHTNESS, 8'h00));
        plan.push_back(cfg_row(REG_DISPLAY_ON, 8'h00));
        plan.push_back(cfg_row(REG_DATA_CMD, 8'h00));
        plan.push_back(cfg_row(REG_ADDRESS_CMD, 8'h00));
        plan.push_back(cfg_row(REG_CONTROL_CMD, 8'h00));
        plan.push_back(req_row(REQ_CTRL, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 5'h01,
                               1, 8'h00));
        plan.push_back(req_row(REQ_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 5'h1E,
                               1, 8'h00));
        plan.push_back(req_row(REQ_ADDR, 8'hAA, 8'h55, 8'h00, 8'h00, 3'd1, 2'd0, 5'h03,
                               1, 8'h00));
        plan.push_back(req_row(REQ_ADDR, 8'h55, 8'hAA, 8'hCC, 8'h33, 3'd2, 2'd1, 5'h06,
                               0, 8'h00));
        plan.push_back(req_row(REQ_ADDR, 8'h96, 8'h69, 8'hE7, 8'h18, 3'd3, 2'd2, 5'h0D,
                               0, 8'h00));
        plan.push_back(cfg_row(REG_BRIGHTNESS, 8'hFD));
        plan.push_back(cfg_row(REG_DISPLAY_ON, 8'hFE));
        plan.push_back(cfg_row(REG_CONTROL_CMD, 8'hF8));
        plan.push_back(req_row(REQ_CTRL, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 5'h00,
                               1, 8'hFD));
        plan.push_back(cfg_row(REG_DISPLAY_ON, 8'h01));
        plan.push_back(req_row(REQ_CTRL, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 5'h01,
                               1, 8'h05));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_register(plan[i].index, plan[i].value);
            else
                push_request(plan[i].word, plan[i].cmd_typed, plan[i].cmd);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_register(REG_BRIGHTNESS, 8'($urandom));
            write_register(REG_DISPLAY_ON, 8'($urandom));
            write_register(REG_DATA_CMD, pick_byte());
            write_register(REG_ADDRESS_CMD, pick_byte());
            write_register(REG_CONTROL_CMD, pick_byte());
            steady <= (phase == STEADY_PHASE);
            counted = 0;
            while (counted < PHASE_WORDS)
            begin
                w = random_request();
                push_request(w, 1'b0, 8'h00);
                if (w.req_type != REQ_NONE)
                    counted++;
            end
        end

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tsdw_pkg.sv
hw/rtl/tsdw_front.sv
hw/rtl/tsdw_queue.sv
hw/rtl/tsdw_back.sv
hw/rtl/two_wire_segment_display_writer_unit.sv
verif/testbench.sv
